// ===== hw/rtl/pbas_pkg.sv =====
// Package for the packed bit array store.
// Holds function and status codes and the controller/datapath command and status types.
// No dependencies.
package pbas_pkg;

    localparam int WORD_BITS = 64;

    localparam logic [1:0] FUNC_GET   = 2'd0;
    localparam logic [1:0] FUNC_SET   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;
    localparam logic [1:0] FUNC_LOAD  = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_IDX  = 2'd1;
    localparam logic [1:0] ST_WIDE = 2'd2;
    localparam logic [1:0] ST_LOAD = 2'd3;

    localparam logic REG_BITS_PER_ENTRY = 1'b0;
    localparam logic REG_ENTRY_COUNT    = 1'b1;

    typedef struct packed {
        logic accept;
        logic rd0;
        logic rd1;
        logic rd2;
        logic load_wr;
        logic sweep;
        logic sweep_all;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic       err;
        logic       used_zero;
        logic       sweep_last;
    } t_sts;

endpackage

// ===== hw/rtl/pbas_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module pbas_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/pbas_dp.sv =====
// Datapath: request decode and checks, word store, read-modify-write and sweep counter.
// Depends on pbas_pkg and pbas_ram.
module pbas_dp import pbas_pkg::*; #(
    parameter int MAX_ENTRIES = 4096,
    parameter int MAX_BITS    = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [5:0]  i_bits_per_entry,
    input  logic [12:0] i_entry_count,
    input  logic [1:0]  i_func,
    input  logic [11:0] i_index,
    input  logic [31:0] i_value,
    input  logic [10:0] i_word_index,
    input  logic [63:0] i_word_data,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic [31:0] o_read_value,
    output logic [1:0]  o_status
);

    localparam int DEPTH = (MAX_ENTRIES * MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int UW    = $clog2(DEPTH + 1);

    logic [5:0]   b_eff;
    logic [12:0]  n_eff;
    logic [18:0]  total;
    logic [13:0]  used_raw;
    logic [UW-1:0] used;
    logic [31:0]  mask;
    logic [17:0]  pos;
    logic [5:0]   tail;
    logic [1:0]   status;

    logic [1:0]   r_func;
    logic [1:0]   r_status;
    logic [31:0]  r_value;
    logic [31:0]  r_mask;
    logic [AW-1:0] r_w;
    logic [5:0]   r_s;
    logic         r_straddle;
    logic [AW-1:0] r_widx;
    logic [63:0]  r_wdata;
    logic [UW-1:0] r_used;
    logic [AW-1:0] r_cnt;
    logic [63:0]  r_lo;
    logic [31:0]  r_rv;
    logic [31:0]  r_out_value;
    logic [1:0]   r_out_status;

    logic [AW-1:0]  w_next;
    logic [127:0]   pair_shift;
    logic [95:0]    m_full;
    logic [95:0]    v_full;
    logic [63:0]    ram_rdata;
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [63:0]    ram_wdata;
    logic [AW-1:0]  ram_raddr;
    logic           sweep_last;

    // effective configuration
    always_comb begin
        if (i_bits_per_entry == 6'd0) begin
            b_eff = 6'd1;
        end else if (32'(i_bits_per_entry) > MAX_BITS) begin
            b_eff = 6'(MAX_BITS);
        end else begin
            b_eff = i_bits_per_entry;
        end
        n_eff    = (32'(i_entry_count) > MAX_ENTRIES) ? 13'(MAX_ENTRIES) : i_entry_count;
        total    = 19'(b_eff) * 19'(n_eff);
        used_raw = 14'((20'(total) + 20'd63) >> 6);
        used     = (32'(used_raw) > DEPTH) ? UW'(DEPTH) : UW'(used_raw);
        tail     = total[5:0];
        mask     = 32'((33'd1 << b_eff) - 33'd1);
        pos      = 18'(i_index) * 18'(b_eff);
    end

    // request checks
    always_comb begin
        status = ST_OK;
        case (i_func)
            FUNC_GET, FUNC_SET: begin
                if (13'(i_index) >= n_eff) begin
                    status = ST_IDX;
                end else if (i_func == FUNC_SET && (i_value & ~mask) != 32'd0) begin
                    status = ST_WIDE;
                end
            end
            FUNC_LOAD: begin
                if (32'(i_word_index) >= 32'(used)) begin
                    status = ST_LOAD;
                end else if (32'(i_word_index) == 32'(used) - 32'd1 && tail != 6'd0
                             && (i_word_data >> tail) != 64'd0) begin
                    status = ST_LOAD;
                end
            end
            default: status = ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func     <= i_func;
            r_status   <= status;
            r_value    <= i_value;
            r_mask     <= mask;
            r_w        <= AW'(pos[17:6]);
            r_s        <= pos[5:0];
            r_straddle <= (7'(pos[5:0]) + 7'(b_eff)) > 7'd64;
            r_widx     <= AW'(i_word_index);
            r_wdata    <= i_word_data;
            r_used     <= used;
        end
        if (i_cmd.rd1) begin
            r_lo <= ram_rdata;
        end
        if (i_cmd.rd2) begin
            r_rv <= pair_shift[31:0] & r_mask;
        end
        if (i_cmd.out_load) begin
            r_out_value  <= (r_func == FUNC_GET && r_status == ST_OK) ? r_rv : 32'd0;
            r_out_status <= r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.sweep) begin
            r_cnt <= sweep_last ? '0 : r_cnt + AW'(1);
        end
    end

    always_comb begin
        w_next     = r_w + AW'(1);
        pair_shift = {ram_rdata, r_lo} >> r_s;
        m_full     = 96'(r_mask) << r_s;
        v_full     = 96'(r_value) << r_s;
        sweep_last = i_cmd.sweep_all ? (r_cnt == AW'(DEPTH - 1))
                                     : (r_cnt == AW'(r_used - UW'(1)));
        ram_raddr  = i_cmd.rd1 ? w_next : r_w;
        ram_we     = 1'b0;
        ram_waddr  = r_w;
        ram_wdata  = 64'd0;
        if (i_cmd.sweep) begin
            ram_we    = 1'b1;
            ram_waddr = r_cnt;
        end else if (i_cmd.load_wr) begin
            ram_we    = 1'b1;
            ram_waddr = r_widx;
            ram_wdata = r_wdata;
        end else if (i_cmd.rd1 && r_func == FUNC_SET) begin
            ram_we    = 1'b1;
            ram_waddr = r_w;
            ram_wdata = (ram_rdata & ~m_full[63:0]) | v_full[63:0];
        end else if (i_cmd.rd2 && r_func == FUNC_SET && r_straddle) begin
            ram_we    = 1'b1;
            ram_waddr = w_next;
            ram_wdata = (ram_rdata & ~{32'd0, m_full[95:64]}) | {32'd0, v_full[95:64]};
        end
    end

    pbas_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        o_sts.func       = r_func;
        o_sts.err        = (r_status != ST_OK);
        o_sts.used_zero  = (r_used == '0);
        o_sts.sweep_last = sweep_last;
    end

    assign o_read_value = r_out_value;
    assign o_status     = r_out_status;

endmodule

// ===== hw/rtl/pbas_ctrl.sv =====
// Controller state machine: init sweep, transaction sequencing and output valid.
// Depends on pbas_pkg.
module pbas_ctrl import pbas_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    output logic o_valid,
    input  logic i_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_INIT = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_DEC  = 4'd2;
    localparam logic [3:0] S_RD0  = 4'd3;
    localparam logic [3:0] S_RD1  = 4'd4;
    localparam logic [3:0] S_RD2  = 4'd5;
    localparam logic [3:0] S_CLR  = 4'd6;
    localparam logic [3:0] S_LOAD = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = (r_state == S_IDLE);
        case (r_state)
            S_INIT: begin
                o_cmd.sweep     = 1'b1;
                o_cmd.sweep_all = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DEC;
                end
            end
            S_DEC: begin
                if (i_sts.err) begin
                    n_state = S_DONE;
                end else begin
                    case (i_sts.func)
                        FUNC_GET, FUNC_SET: n_state = S_RD0;
                        FUNC_CLEAR:         n_state = i_sts.used_zero ? S_DONE : S_CLR;
                        FUNC_LOAD:          n_state = S_LOAD;
                        default:            n_state = S_DONE;
                    endcase
                end
            end
            S_RD0: begin
                o_cmd.rd0 = 1'b1;
                n_state   = S_RD1;
            end
            S_RD1: begin
                o_cmd.rd1 = 1'b1;
                n_state   = S_RD2;
            end
            S_RD2: begin
                o_cmd.rd2 = 1'b1;
                n_state   = S_DONE;
            end
            S_CLR: begin
                o_cmd.sweep = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_DONE;
                end
            end
            S_LOAD: begin
                o_cmd.load_wr = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

`ifndef SYNTHESIS
    a_no_result_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> !r_out_valid)
        else $error("result valid during init sweep");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_ready))
        else $error("pending result overwritten");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready held after accept");

    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside done state");
`endif

endmodule

// ===== hw/rtl/packed_bit_array_store.sv =====
// Packed bit array store: each request steps through decode and done; an error-free get
// or set adds RD0, RD1 and RD2, a load word adds load, a clear a sweep of the words in use.
// One transaction at a time, each bounded by its word RAM accesses.
// Reset (synchronous, active low): config to 1 bit/entry and 0 entries; the RAM is
// zeroed by a sweep of (MAX_ENTRIES*MAX_BITS+63)/64 words (2048 by default), o_ready low.
// Depends on pbas_pkg, pbas_ctrl, pbas_dp, pbas_ram.
module packed_bit_array_store import pbas_pkg::*; #(
    parameter int MAX_ENTRIES = 4096,
    parameter int MAX_BITS    = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_func,
    input  logic [11:0] i_index,
    input  logic [31:0] i_value,
    input  logic [10:0] i_word_index,
    input  logic [63:0] i_word_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_read_value,
    output logic [1:0]  o_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [5:0]  r_bits_per_entry;
    logic [12:0] r_entry_count;
    logic        cfg_wr;
    t_cmd        cmd;
    t_sts        sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits_per_entry <= 6'd1;
            r_entry_count    <= 13'd0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_BITS_PER_ENTRY) begin
                r_bits_per_entry <= pwdata[5:0];
            end else begin
                r_entry_count <= pwdata[12:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_ENTRY_COUNT) ? {19'd0, r_entry_count}
                                                  : {26'd0, r_bits_per_entry};

    pbas_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    pbas_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_BITS    (MAX_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_bits_per_entry (r_bits_per_entry),
        .i_entry_count    (r_entry_count),
        .i_func           (i_func),
        .i_index          (i_index),
        .i_value          (i_value),
        .i_word_index     (i_word_index),
        .i_word_data      (i_word_data),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_read_value     (o_read_value),
        .o_status         (o_status)
    );

endmodule

// ===== tb/tb_packed_bit_array_store.sv =====
// Testbench for packed_bit_array_store: directed and random get/set/clear/load-word traffic
// checked against an in-bench model of the packed word store, with APB register setup.
// Depends on pbas_pkg and the packed_bit_array_store RTL.
module tb_packed_bit_array_store;
    import pbas_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ENTRIES   = 4096;
    localparam int MAX_BITS      = 32;
    localparam int STORE_WORDS   = (MAX_ENTRIES * MAX_BITS + 63) / 64;
    localparam int CYCLE_LIMIT   = 1500000;
    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 150;
    localparam int PHASES        = 12;

    localparam logic [2:0] ADDR_BITS_PER_ENTRY = {REG_BITS_PER_ENTRY, 2'b00};
    localparam logic [2:0] ADDR_ENTRY_COUNT    = {REG_ENTRY_COUNT, 2'b00};

    typedef struct {
        logic [1:0]  func;
        logic [11:0] index;
        logic [31:0] value;
        logic [10:0] word_index;
        logic [63:0] word_data;
    } t_request;

    typedef struct {
        logic [31:0] read_value;
        logic [1:0]  status;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_func = '0;
    logic [11:0] i_index = '0;
    logic [31:0] i_value = '0;
    logic [10:0] i_word_index = '0;
    logic [63:0] i_word_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_read_value;
    logic [1:0]  o_status;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    packed_bit_array_store u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_func       (i_func),
        .i_index      (i_index),
        .i_value      (i_value),
        .i_word_index (i_word_index),
        .i_word_data  (i_word_data),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // model state
    logic [5:0]  cfg_width = 6'd1;
    logic [12:0] cfg_count = 13'd0;
    logic [63:0] word_mem [STORE_WORDS];

    t_result pending_results [$];
    t_result oldest;
    int      error_count = 0;
    int      cycle_count = 0;
    bit      no_idle = 1'b0;
    int      hold_requests = 0;
    int      holds_granted = 0;
    int      hold_left = 0;
    int      stall_left = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int eff_width();
        if (cfg_width == 0) return 1;
        if (cfg_width > MAX_BITS) return MAX_BITS;
        return int'(cfg_width);
    endfunction

    function automatic int eff_count();
        return (cfg_count > MAX_ENTRIES) ? MAX_ENTRIES : int'(cfg_count);
    endfunction

    function automatic int words_in_use();
        return (eff_width() * eff_count() + 63) / 64;
    endfunction

    task automatic predict_request(input t_request r, output t_result e);
        int          b, n, used, pos, w, s, hi, tail;
        bit          straddle;
        logic [63:0] mask, m2, v, val;
        b    = eff_width();
        n    = eff_count();
        used = words_in_use();
        mask = (64'd1 << b) - 64'd1;
        val  = {32'd0, r.value};
        e.read_value = '0;
        e.status     = ST_OK;
        if (r.func == FUNC_GET || r.func == FUNC_SET) begin
            if (int'(r.index) >= n) begin
                e.status = ST_IDX;
            end else begin
                pos      = int'(r.index) * b;
                w        = pos / 64;
                s        = pos % 64;
                straddle = (s + b) > 64;
                if (r.func == FUNC_GET) begin
                    v = word_mem[w] >> s;
                    if (straddle) v |= word_mem[w + 1] << (64 - s);
                    v = v & mask;
                    e.read_value = v[31:0];
                end else if (val > mask) begin
                    e.status = ST_WIDE;
                end else begin
                    word_mem[w] = (word_mem[w] & ~(mask << s)) | (val << s);
                    if (straddle) begin
                        hi = s + b - 64;
                        m2 = (64'd1 << hi) - 64'd1;
                        word_mem[w + 1] = (word_mem[w + 1] & ~m2) | (val >> (64 - s));
                    end
                end
            end
        end else if (r.func == FUNC_CLEAR) begin
            for (int i = 0; i < used; i++) word_mem[i] = '0;
        end else begin
            tail = (b * n) % 64;
            if (int'(r.word_index) >= used) begin
                e.status = ST_LOAD;
            end else if (int'(r.word_index) == used - 1 && tail != 0 &&
                         (r.word_data >> tail) != 64'd0) begin
                e.status = ST_LOAD;
            end else begin
                word_mem[r.word_index] = r.word_data;
            end
        end
    endtask

    function automatic int idle_gap();
        int roll;
        if (no_idle) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    // result sink: random stalls plus long hold-offs on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (holds_granted != hold_requests) begin
            holds_granted++;
            hold_left = HOLD_CYCLES - 1;
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else begin
            stall_left = idle_gap();
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction: read_value %h status %0d",
                       o_read_value, o_status);
                error_count++;
            end else begin
                oldest = pending_results.pop_front();
                if (o_read_value !== oldest.read_value) begin
                    $error("read_value: expected %h, actual %h", oldest.read_value, o_read_value);
                    error_count++;
                end
                if (o_status !== oldest.status) begin
                    $error("status: expected %0d, actual %0d", oldest.status, o_status);
                    error_count++;
                end
            end
        end
    end

    task automatic send_request(input t_request r);
        t_result e;
        int      gap;
        gap = idle_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_func       <= r.func;
        i_index      <= r.index;
        i_value      <= r.value;
        i_word_index <= r.word_index;
        i_word_data  <= r.word_data;
        i_valid      <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_request(r, e);
        pending_results.push_back(e);
    endtask

    task automatic send_fields(input logic [1:0] func, input logic [11:0] index,
                               input logic [31:0] value, input logic [10:0] word_index,
                               input logic [63:0] word_data);
        t_request r;
        r.func       = func;
        r.index      = index;
        r.value      = value;
        r.word_index = word_index;
        r.word_data  = word_data;
        send_request(r);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0 || !o_ready) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
        logic [31:0] stored;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (addr == ADDR_BITS_PER_ENTRY) begin
            cfg_width = data[5:0];
            stored    = {26'd0, data[5:0]};
        end else begin
            cfg_count = data[12:0];
            stored    = {19'd0, data[12:0]};
        end
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== stored) begin
            $error("prdata: expected %h, actual %h", stored, prdata);
            error_count++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(input int width, input int count);
        wait_idle();
        write_register(ADDR_BITS_PER_ENTRY, width);
        write_register(ADDR_ENTRY_COUNT, count);
    endtask

    function automatic t_request random_request();
        t_request    r;
        int          b, n, used, tail, roll;
        logic [31:0] vmask;
        b     = eff_width();
        n     = eff_count();
        used  = words_in_use();
        tail  = (b * n) % 64;
        vmask = (b == 32) ? 32'hFFFF_FFFF : ((32'd1 << b) - 32'd1);
        r.index      = 12'($urandom);
        r.value      = $urandom;
        r.word_index = 11'($urandom);
        r.word_data  = {$urandom, $urandom};
        roll = $urandom_range(0, 99);
        if (roll < 40)      r.func = FUNC_GET;
        else if (roll < 75) r.func = FUNC_SET;
        else if (roll < 78) r.func = FUNC_CLEAR;
        else                r.func = FUNC_LOAD;
        if (n > 0 && $urandom_range(0, 9) != 0) begin
            r.index = ($urandom_range(0, 7) == 0) ? 12'(n - 1) : 12'($urandom_range(0, n - 1));
        end
        roll = $urandom_range(0, 15);
        if (roll == 0)      r.value = vmask;
        else if (roll == 1) r.value = '0;
        else if (roll > 2)  r.value = r.value & vmask;
        if (used > 0 && $urandom_range(0, 9) != 0) begin
            r.word_index = ($urandom_range(0, 3) == 0) ? 11'(used - 1)
                                                       : 11'($urandom_range(0, used - 1));
            if (int'(r.word_index) == used - 1 && tail != 0 && $urandom_range(0, 3) != 0)
                r.word_data = r.word_data & ((64'd1 << tail) - 64'd1);
        end
        return r;
    endfunction

    task automatic test_reset_defaults();
        send_fields(FUNC_GET, 12'd0, 32'd0, 11'd0, 64'd0);
        send_fields(FUNC_SET, 12'd0, 32'd0, 11'd0, 64'd0);
        send_fields(FUNC_LOAD, 12'd0, 32'd0, 11'd0, 64'd0);
        send_fields(FUNC_CLEAR, 12'd0, 32'd0, 11'd0, 64'd0);
    endtask

    task automatic test_edge_cases();
        // 7-bit entries, 100 of them: 11 words, 60 bits used in the last
        configure(7, 100);
        send_fields(FUNC_SET, 12'd9, 32'h55, 11'd0, 64'd0);
        send_fields(FUNC_GET, 12'd9, 32'd0, 11'd0, 64'd0);
        send_fields(FUNC_SET, 12'd99, 32'h7F, 11'd0, 64'd0);
        send_fields(FUNC_SET, 12'd0, 32'h80, 11'd0, 64'd0);
        send_fields(FUNC_SET, 12'd100, 32'h80, 11'd0, 64'd0);
        send_fields(FUNC_GET, 12'd4095, 32'd0, 11'd0, 64'd0);
        send_fields(FUNC_LOAD, 12'd0, 32'd0, 11'd10, 64'd1 << 60);
        send_fields(FUNC_LOAD, 12'd0, 32'd0, 11'd10, 64'h0FFF_FFFF_FFFF_FFFF);
        send_fields(FUNC_GET, 12'd99, 32'd0, 11'd0, 64'd0);
        send_fields(FUNC_LOAD, 12'd0, 32'd0, 11'd11, 64'd0);
        send_fields(FUNC_LOAD, 12'd0, 32'd0, 11'd9, '1);
        send_fields(FUNC_GET, 12'd80, 32'd0, 11'd0, 64'd0);
        send_fields(FUNC_CLEAR, 12'd0, 32'd0, 11'd0, 64'd0);
        send_fields(FUNC_GET, 12'd9, 32'd0, 11'd0, 64'd0);
        // zero width acts as one bit, oversized count as the maximum
        configure(0, 8191);
        send_fields(FUNC_SET, 12'd4095, 32'd1, 11'd0, 64'd0);
        send_fields(FUNC_GET, 12'd4095, 32'd0, 11'd0, 64'd0);
        send_fields(FUNC_SET, 12'd0, 32'd2, 11'd0, 64'd0);
        send_fields(FUNC_LOAD, 12'd0, 32'd0, 11'd2047, 64'd0);
        // oversized width acts as 32 bits
        configure(63, 4096);
        send_fields(FUNC_SET, 12'd4095, 32'hFFFF_FFFF, 11'd0, 64'd0);
        send_fields(FUNC_GET, 12'd4095, 32'd0, 11'd0, 64'd0);
        send_fields(FUNC_LOAD, 12'd0, 32'd0, 11'd2047, 64'hA5A5_5A5A_0123_4567);
        send_fields(FUNC_GET, 12'd4094, 32'd0, 11'd0, 64'd0);
        send_fields(FUNC_CLEAR, 12'd0, 32'd0, 11'd0, 64'd0);
    endtask

    task automatic test_random_phases();
        int width, count;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin width = 1;  count = 4096; end
                1: begin width = 32; count = 4096; end
                2: begin width = 0;  count = 8191; end
                3: begin width = 63; count = 37;   end
                4: begin width = 5;  count = 1;    end
                default: begin
                    width = $urandom_range(0, 63);
                    count = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                                        : $urandom_range(0, 300);
                end
            endcase
            configure(width, count);
            no_idle = (p % 4 == 3);
            repeat (PHASE_ITEMS) send_request(random_request());
            no_idle = 1'b0;
        end
    endtask

    task automatic test_output_stall();
        configure(9, 500);
        hold_requests++;
        no_idle = 1'b1;
        repeat (40) send_request(random_request());
        no_idle = 1'b0;
    endtask

    initial begin
        foreach (word_mem[i]) word_mem[i] = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_edge_cases();
        test_random_phases();
        test_output_stall();
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
